// File: hdl/dexg_pkg.sv
// ----------------------------------------------------------------------------
// dexg_pkg
// shared types and constants of the downward expander gain block
// ----------------------------------------------------------------------------
package dexg_pkg;

  // fixed field widths
  localparam int GAIN_W   = 17;
  localparam int ACC_W    = 27;
  localparam int FRAMES_W = 32;
  localparam int TERM_W   = 34;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;
  localparam logic [ACC_W-1:0]  ACCUM_MAX  = 27'h7FF_FFFF;
  // 6.0206 dB per octave, scaled by 2^24
  localparam logic [26:0]       DB_PER_OCTAVE_Q = 27'd101008905;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_THR   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF     = 4'd3;

  typedef struct packed {
    logic [14:0] thr;
    logic [31:0] inv;
    logic [15:0] depth;
    logic [15:0] coeff;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{thr: 15'd1036, inv: 32'd2072860,
                                 depth: 16'd58982, coeff: 16'd64066};

endpackage

// File: hdl/downward_expander_gain_top.sv
// ----------------------------------------------------------------------------
// downward_expander_gain_top
// downward expander with linear knee: per-sample smoothed gain, scaled
// sample, saturating frame sum of gain reduction in dB and frame count
//
// input channel: in_valid_i / in_stall_o with sample_in_i, frame_start_i,
//   frame_end_i; a request is taken when valid is high and stall is low
// output channel: out_valid_o / out_stall_i, one result request per sample
// config channel: cfg_valid_i / cfg_ready_o, always ready; index 0 threshold,
//   1 inverse threshold, 2 depth, 3 smoothing coefficient; other indexes are
//   dropped; write only while the block is idle
// latency: LOG_TABLE_BITS + 6 cycles from accept to result valid
// throughput: one sample every LOG_TABLE_BITS + 4 cycles, set by the back
//   sequencer (gain update, product, one log bit per cycle, dB scaling, sum)
// the front pipeline and a two-entry queue keep taking samples while the
//   back works or the result register waits
// reset: registers return to their defaults, gain to unity, sum and frame
//   count to zero, no result pending
// a stalled result holds; the back waits and the queue then fills and stalls
//   the input side
// ----------------------------------------------------------------------------
module downward_expander_gain_top #(
  parameter int SAMPLE_BITS    = 16,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dexg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dexg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // sample input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  input  logic                              frame_start_i,
  input  logic                              frame_end_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o,
  output logic [dexg_pkg::GAIN_W-1:0]       gain_now_o,
  output logic [dexg_pkg::ACC_W-1:0]        reduction_sum_o,
  output logic [dexg_pkg::FRAMES_W-1:0]     frames_done_o,
  output logic                              last_o
);
  import dexg_pkg::*;

  // queue entry: magnitude, sign, start, end, gain term
  localparam int EntryW = SAMPLE_BITS + 3 + TERM_W;

  cfg_t cfg_q, cfg_d;

  logic                   push, pop, q_full, q_empty;
  logic [SAMPLE_BITS-1:0] f_mag, b_mag, b_sample;
  logic                   f_neg, f_start, f_end, b_neg, b_start, b_end;
  logic [TERM_W-1:0]      f_term, b_term;
  logic [EntryW-1:0]      q_wdata, q_rdata;

  // config registers, always ready, unknown index is ignored
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: cfg_d.thr   = cfg_data_i[14:0];
        CFG_INV_THR:   cfg_d.inv   = cfg_data_i;
        CFG_DEPTH:     cfg_d.depth = cfg_data_i[15:0];
        CFG_COEFF:     cfg_d.coeff = cfg_data_i[15:0];
        default:       cfg_d       = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: magnitude, threshold compare and target gain term
  dexg_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_in_i),
    .start_i    (frame_start_i),
    .end_i      (frame_end_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .mag_o      (f_mag),
    .neg_o      (f_neg),
    .start_o    (f_start),
    .end_o      (f_end),
    .term_o     (f_term)
  );

  assign q_wdata = {f_mag, f_neg, f_start, f_end, f_term};

  // queue lets front and back stall on their own
  dexg_queue #(
    .WIDTH (EntryW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  assign {b_mag, b_neg, b_start, b_end, b_term} = q_rdata;

  // back: gain smoother, scaling, log reduction and result register
  dexg_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coeff_i     (cfg_q.coeff),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .mag_i       (b_mag),
    .neg_i       (b_neg),
    .start_i     (b_start),
    .end_i       (b_end),
    .term_i      (b_term),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (b_sample),
    .gain_o      (gain_now_o),
    .sum_o       (reduction_sum_o),
    .frames_o    (frames_done_o),
    .last_o      (last_o)
  );

  assign sample_out_o = b_sample;

endmodule

// File: hdl/dexg_front.sv
// ----------------------------------------------------------------------------
// dexg_front
// takes samples, finds magnitude, threshold class and target gain term
// ----------------------------------------------------------------------------
module dexg_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dexg_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [SAMPLE_BITS-1:0]         sample_i,
  input  logic                           start_i,
  input  logic                           end_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output logic [SAMPLE_BITS-1:0]         mag_o,
  output logic                           neg_o,
  output logic                           start_o,
  output logic                           end_o,
  output logic [dexg_pkg::TERM_W-1:0]    term_o
);
  import dexg_pkg::*;

  localparam int CmpW = SAMPLE_BITS + 15;
  localparam int P1W  = 47;

  logic                   v1_q, v1_d, v2_q, v2_d;
  logic                   ready1, ready2, accept, move12;
  logic                   neg_s, below_s;
  logic [SAMPLE_BITS-1:0] mag_s;
  logic [P1W-1:0]         p1_s;

  logic [SAMPLE_BITS-1:0] mag1_q, mag2_q;
  logic                   neg1_q, neg2_q, st1_q, st2_q, en1_q, en2_q, below1_q;
  logic [P1W-1:0]         p1_q;
  logic [GAIN_W-1:0]      target2_q;

  logic [P1W-1:0]         ratio_full;
  logic [GAIN_W-1:0]      ratio, target_s;
  logic [32:0]            p2_s;

  assign ready2     = !v2_q || !q_full_i;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;
  assign accept     = in_valid_i && ready1;
  assign move12     = v1_q && ready2;
  assign push_o     = v2_q && !q_full_i;

  // magnitude, most negative sample keeps its sign bit pattern
  always_comb begin
    neg_s   = sample_i[SAMPLE_BITS-1];
    mag_s   = neg_s ? ((~sample_i) + {{(SAMPLE_BITS-1){1'b0}}, 1'b1}) : sample_i;
    below_s = CmpW'(mag_s) < CmpW'(cfg_i.thr);
    p1_s    = P1W'(15'(mag_s)) * P1W'(cfg_i.inv);
  end

  // ratio saturation and target gain
  always_comb begin
    ratio_full = p1_q >> (SAMPLE_BITS - 1);
    ratio      = (ratio_full > P1W'(UNITY_GAIN)) ? UNITY_GAIN : ratio_full[GAIN_W-1:0];
    p2_s       = 33'(UNITY_GAIN - ratio) * 33'(cfg_i.depth);
    target_s   = below1_q ? (UNITY_GAIN - p2_s[32:16]) : UNITY_GAIN;
  end

  always_comb begin
    v1_d = accept ? 1'b1 : (move12 ? 1'b0 : v1_q);
    v2_d = move12 ? 1'b1 : (push_o ? 1'b0 : v2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag1_q   <= mag_s;
      neg1_q   <= neg_s;
      st1_q    <= start_i;
      en1_q    <= end_i;
      below1_q <= below_s;
      p1_q     <= p1_s;
    end
    if (move12) begin
      mag2_q    <= mag1_q;
      neg2_q    <= neg1_q;
      st2_q     <= st1_q;
      en2_q     <= en1_q;
      target2_q <= target_s;
    end
  end

  // (1 - a) * target half of the one-pole update
  assign term_o  = TERM_W'(UNITY_GAIN - {1'b0, cfg_i.coeff}) * TERM_W'(target2_q);
  assign mag_o   = mag2_q;
  assign neg_o   = neg2_q;
  assign start_o = st2_q;
  assign end_o   = en2_q;

endmodule

// File: hdl/dexg_queue.sv
// ----------------------------------------------------------------------------
// dexg_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module dexg_queue #(
  parameter int WIDTH = 52
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import dexg_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: hdl/dexg_back.sv
// ----------------------------------------------------------------------------
// dexg_back
// gain smoother, sample scaling, log reduction, frame sum and result register
// ----------------------------------------------------------------------------
module dexg_back #(
  parameter int SAMPLE_BITS    = 16,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [15:0]                   coeff_i,
  input  logic                          q_empty_i,
  output logic                          pop_o,
  input  logic [SAMPLE_BITS-1:0]        mag_i,
  input  logic                          neg_i,
  input  logic                          start_i,
  input  logic                          end_i,
  input  logic [dexg_pkg::TERM_W-1:0]   term_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [SAMPLE_BITS-1:0]        sample_o,
  output logic [dexg_pkg::GAIN_W-1:0]   gain_o,
  output logic [dexg_pkg::ACC_W-1:0]    sum_o,
  output logic [dexg_pkg::FRAMES_W-1:0] frames_o,
  output logic                          last_o
);
  import dexg_pkg::*;

  localparam int L    = LOG_TABLE_BITS;
  localparam int CW   = $clog2(L);
  localparam int DW   = L + 5;
  localparam int PW   = L + 32;
  localparam int ProdW = SAMPLE_BITS + 17;
  localparam int RsW  = SAMPLE_BITS + 18;
  localparam int RpW  = SAMPLE_BITS + 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_LOG   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [GAIN_W-1:0]      gain_q, gain_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [FRAMES_W-1:0]    frames_q, frames_d;
  logic                   ovalid_q, ovalid_d;
  logic [CW-1:0]          cnt_q, cnt_d;

  logic [SAMPLE_BITS-1:0] mag_q;
  logic                   neg_q, end_q;
  logic [ProdW-1:0]       prod_q;
  logic [4:0]             e_q;
  logic [16:0]            m_q, m_d;
  logic [L-1:0]           frac_q, frac_d;
  logic [PW-1:0]          dbp_q;
  logic [SAMPLE_BITS-1:0] osample_q;
  logic [GAIN_W-1:0]      ogain_q;
  logic [ACC_W-1:0]       osum_q;
  logic [FRAMES_W-1:0]    oframes_q;
  logic                   olast_q;

  logic                   out_load;
  logic [GAIN_W-1:0]      g_eff, g_log, g_new;
  logic [34:0]            gsum;
  logic [4:0]             e_s;
  logic [16:0]            m_init;
  logic [33:0]            sq;
  logic [17:0]            sqs;
  logic [DW-1:0]          d_s;
  logic [PW-1:0]          red_full;
  logic [15:0]            red;
  logic [ACC_W:0]         acc_sum;
  logic [ACC_W-1:0]       acc_new;
  logic [RsW-1:0]         rsum;
  logic [RpW-1:0]         rp, rsign, rclip;
  logic [SAMPLE_BITS-1:0] sample_s;

  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i;
  assign out_load = (state_q == ST_OUT) && (!ovalid_q || !out_stall_i);

  // one-pole gain update, gain returns to unity at frame start
  always_comb begin
    g_eff = start_i ? UNITY_GAIN : gain_q;
    gsum  = 35'(coeff_i) * 35'(g_eff) + 35'(term_i) + 35'd32768;
    g_new = gsum[32:16];
  end

  // normalize gain for the log
  always_comb begin
    g_log = (gain_q == '0) ? 17'd1 : gain_q;
    e_s   = 5'd0;
    for (int i = 0; i < GAIN_W; i++) begin
      if (g_log[i]) begin
        e_s = 5'(i);
      end
    end
    m_init = g_log << (5'd16 - e_s);
  end

  // one log bit per cycle by squaring
  always_comb begin
    sq     = 34'(m_q) * 34'(m_q);
    sqs    = sq[33:16];
    m_d    = sqs[17] ? sqs[17:1] : sqs[16:0];
    frac_d = {frac_q[L-2:0], sqs[17]};
  end

  always_comb begin
    d_s = (DW'(5'd16 - e_q) << L) - DW'(frac_q);
  end

  // reduction in dB and saturating frame sum
  always_comb begin
    red_full = (dbp_q + (PW'(1) << (15 + L))) >> (16 + L);
    red      = red_full[15:0];
    acc_sum  = {1'b0, acc_q} + (ACC_W + 1)'(red);
    acc_new  = (acc_sum > {1'b0, ACCUM_MAX}) ? ACCUM_MAX : acc_sum[ACC_W-1:0];
  end

  // rounded scaled sample, clipped to the signed range
  always_comb begin
    rsum  = RsW'(prod_q) + RsW'(32768);
    rp    = RpW'(rsum >> 16);
    rsign = RpW'(1) << (SAMPLE_BITS - 1);
    if (neg_q) begin
      rclip    = (rp > rsign) ? rsign : rp;
      sample_s = (~rclip[SAMPLE_BITS-1:0]) + {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
    end else begin
      rclip    = (rp > rsign - 1'b1) ? (rsign - 1'b1) : rp;
      sample_s = rclip[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    gain_d   = gain_q;
    acc_d    = acc_q;
    frames_d = frames_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          gain_d  = g_new;
          if (start_i) begin
            acc_d = '0;
          end
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_d   = '0;
        state_d = ST_LOG;
      end
      ST_LOG: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(L - 1)) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          acc_d    = acc_new;
          frames_d = end_q ? frames_q + 1'b1 : frames_q;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      gain_q   <= UNITY_GAIN;
      acc_q    <= '0;
      frames_q <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      gain_q   <= gain_d;
      acc_q    <= acc_d;
      frames_q <= frames_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mag_q <= mag_i;
      neg_q <= neg_i;
      end_q <= end_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= ProdW'(mag_q) * ProdW'(gain_q);
      e_q    <= e_s;
      m_q    <= m_init;
      frac_q <= '0;
    end
    if (state_q == ST_LOG) begin
      m_q    <= m_d;
      frac_q <= frac_d;
    end
    if (state_q == ST_SCALE) begin
      dbp_q <= PW'(d_s) * PW'(DB_PER_OCTAVE_Q);
    end
    if (out_load) begin
      osample_q <= sample_s;
      ogain_q   <= gain_q;
      osum_q    <= acc_new;
      oframes_q <= end_q ? frames_q + 1'b1 : frames_q;
      olast_q   <= end_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign sample_o    = osample_q;
  assign gain_o      = ogain_q;
  assign sum_o       = osum_q;
  assign frames_o    = oframes_q;
  assign last_o      = olast_q;

endmodule

// File: test/expander_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// expander_checker
// watches the config, sample and result channels of the downward expander,
// predicts every result from the accepted samples and register writes, and
// compares the results in order, field by field
// ----------------------------------------------------------------------------
module expander_checker #(
  parameter int SAMPLE_BITS    = 16,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [dexg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dexg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [SAMPLE_BITS-1:0]            sample_in_i,
  input  logic                              frame_start_i,
  input  logic                              frame_end_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_out_i,
  input  logic [dexg_pkg::GAIN_W-1:0]       gain_now_i,
  input  logic [dexg_pkg::ACC_W-1:0]        reduction_sum_i,
  input  logic [dexg_pkg::FRAMES_W-1:0]     frames_done_i,
  input  logic                              last_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                frame_ends_o,
  output logic                              ceiling_hit_o
);
  import dexg_pkg::*;

  localparam logic [63:0] UNITY    = 64'd65536;
  localparam logic [63:0] SIGN_MAG = 64'd1 << (SAMPLE_BITS - 1);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [GAIN_W-1:0]      gain;
    logic [ACC_W-1:0]       sum;
    logic [FRAMES_W-1:0]    frames;
    logic                   last;
  } expander_result_t;

  cfg_t                 regs;
  logic [GAIN_W-1:0]    gain_q;
  logic [ACC_W-1:0]     loss_sum_q;
  logic [FRAMES_W-1:0]  frame_cnt_q;
  expander_result_t     due_results[$];
  expander_result_t     want;
  int                   mismatches;
  int                   checked;
  int                   frame_ends;
  logic                 ceiling_hit;

  // gain reduction in dB, Q8.8, from a log2 with LOG_TABLE_BITS fraction bits
  function automatic logic [31:0] gain_loss_db(input logic [GAIN_W-1:0] gain);
    logic [63:0] gv;
    logic [63:0] m;
    logic [63:0] bits_below;
    int unsigned octave;
    logic [31:0] frac;
    gv = 64'(gain);
    if (gv == 64'd0) gv = 64'd1;
    if (gv > UNITY) gv = UNITY;
    octave = 0;
    while (octave < 16 && (gv >> (octave + 1)) != 64'd0) octave++;
    m = gv << (16 - octave);
    frac = '0;
    for (int k = 0; k < LOG_TABLE_BITS; k++) begin
      m = (m * m) >> 16;
      frac = frac << 1;
      if (m >= 64'd131072) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    bits_below = (64'd16 << LOG_TABLE_BITS) - ((64'(octave) << LOG_TABLE_BITS) + 64'(frac));
    return 32'((bits_below * 64'(DB_PER_OCTAVE_Q) + (64'd1 << (15 + LOG_TABLE_BITS)))
               >> (16 + LOG_TABLE_BITS));
  endfunction

  // advances gain, sum and frame count by one sample
  function automatic expander_result_t expand_sample(input logic [SAMPLE_BITS-1:0] x,
                                                     input logic start, input logic stop);
    logic                 neg;
    logic [SAMPLE_BITS:0] abs_x;
    logic [63:0]          mag;
    logic [63:0]          ratio;
    logic [63:0]          target;
    logic [63:0]          g;
    logic [63:0]          prod;
    logic [63:0]          sumw;
    expander_result_t     r;
    neg = x[SAMPLE_BITS-1];
    abs_x = neg ? (~{1'b1, x} + 1'b1) : {1'b0, x};
    mag = 64'(abs_x);
    if (start) begin
      gain_q = UNITY_GAIN;
      loss_sum_q = '0;
    end
    target = UNITY;
    if (abs_x < regs.thr) begin
      ratio = (mag * 64'(regs.inv)) >> (SAMPLE_BITS - 1);
      if (ratio > UNITY) ratio = UNITY;
      target = UNITY - (((UNITY - ratio) * 64'(regs.depth)) >> 16);
    end
    g = (64'(regs.coeff) * 64'(gain_q) + (UNITY - 64'(regs.coeff)) * target + 64'd32768) >> 16;
    gain_q = g[GAIN_W-1:0];
    prod = (mag * g + 64'd32768) >> 16;
    if (neg) begin
      if (prod > SIGN_MAG) prod = SIGN_MAG;
      prod = -prod;
    end else if (prod > SIGN_MAG - 1) begin
      prod = SIGN_MAG - 1;
    end
    sumw = 64'(loss_sum_q) + 64'(gain_loss_db(gain_q));
    loss_sum_q = (sumw > 64'(ACCUM_MAX)) ? ACCUM_MAX : sumw[ACC_W-1:0];
    if (stop) frame_cnt_q = frame_cnt_q + 1'b1;
    r.sample = prod[SAMPLE_BITS-1:0];
    r.gain   = gain_q;
    r.sum    = loss_sum_q;
    r.frames = frame_cnt_q;
    r.last   = stop;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = CFG_RESET;
      gain_q = UNITY_GAIN;
      loss_sum_q = '0;
      frame_cnt_q = '0;
      due_results.delete();
      mismatches = 0;
      checked = 0;
      frame_ends = 0;
      ceiling_hit = 1'b0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      frame_ends_o <= 0;
      ceiling_hit_o <= 1'b0;
    end else begin
      // results are compared before this edge's sample is predicted
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result request with no sample waiting for it");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          checked++;
          if (want.sum == ACCUM_MAX) ceiling_hit = 1'b1;
          if (sample_out_i !== $signed(want.sample)) begin
            $error("sample_out: expected %0d, actual %0d", $signed(want.sample), sample_out_i);
            mismatches++;
          end
          if (gain_now_i !== want.gain) begin
            $error("gain_now: expected %0d, actual %0d", want.gain, gain_now_i);
            mismatches++;
          end
          if (reduction_sum_i !== want.sum) begin
            $error("reduction_sum: expected %0d, actual %0d", want.sum, reduction_sum_i);
            mismatches++;
          end
          if (frames_done_i !== want.frames) begin
            $error("frames_done: expected %0d, actual %0d", want.frames, frames_done_i);
            mismatches++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_i);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: regs.thr   = cfg_data_i[14:0];
          CFG_INV_THR:   regs.inv   = cfg_data_i;
          CFG_DEPTH:     regs.depth = cfg_data_i[15:0];
          CFG_COEFF:     regs.coeff = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        due_results.push_back(expand_sample(sample_in_i, frame_start_i, frame_end_i));
        if (frame_end_i) frame_ends++;
      end
      fail_count_o <= mismatches;
      pending_o <= due_results.size();
      checked_o <= checked;
      frame_ends_o <= frame_ends;
      ceiling_hit_o <= ceiling_hit;
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives the downward expander with directed samples, then framed random
// audio over a series of register settings, and lets the checker compare
// every result; both channels idle at random and the result side holds off
// once for a long stretch so the input side backs up
// ----------------------------------------------------------------------------
module testbench;

  localparam int SB          = 16;
  localparam int LB          = 6;
  localparam int IDX_W       = dexg_pkg::CFG_IDX_W;
  // accept to result when nothing stalls
  localparam int LATENCY     = LB + 6;
  localparam int MAX_POS     = 2 ** (SB - 1) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1_000_000;
  // long single frame at the gain floor that builds up a large reduction sum
  localparam int LONG_FRAME  = 250;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic [dexg_pkg::CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [dexg_pkg::CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                              cfg_ready_o;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic signed [SB-1:0]              sample_in_i = '0;
  logic                              frame_start_i = 1'b0;
  logic                              frame_end_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [SB-1:0]              sample_out_o;
  logic [dexg_pkg::GAIN_W-1:0]       gain_now_o;
  logic [dexg_pkg::ACC_W-1:0]        reduction_sum_o;
  logic [dexg_pkg::FRAMES_W-1:0]     frames_done_o;
  logic                              last_o;

  // checker status
  int   fail_count;
  int   open_count;
  int   checked_count;
  int   frame_end_count;
  logic ceiling_hit;

  // stimulus bookkeeping
  int   cycle_count = 0;
  int   samples_sent = 0;
  int   settings_used = 1;
  int   cur_thr = 1036;
  logic no_gaps = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  downward_expander_gain_top #(
    .SAMPLE_BITS    (SB),
    .LOG_TABLE_BITS (LB)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_in_i     (sample_in_i),
    .frame_start_i   (frame_start_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_o    (sample_out_o),
    .gain_now_o      (gain_now_o),
    .reduction_sum_o (reduction_sum_o),
    .frames_done_o   (frames_done_o),
    .last_o          (last_o)
  );

  expander_checker #(
    .SAMPLE_BITS    (SB),
    .LOG_TABLE_BITS (LB)
  ) gain_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .sample_in_i     (sample_in_i),
    .frame_start_i   (frame_start_i),
    .frame_end_i     (frame_end_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_i    (sample_out_o),
    .gain_now_i      (gain_now_o),
    .reduction_sum_i (reduction_sum_o),
    .frames_done_i   (frames_done_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (open_count),
    .checked_o       (checked_count),
    .frame_ends_o    (frame_end_count),
    .ceiling_hit_o   (ceiling_hit)
  );

  // result side: random stalls, one long hold-off on request, none while
  // no_gaps is set
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_gaps && ($urandom_range(99) < 23);
    end
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one sample request, with random idle cycles ahead of it, and wait
  // until the block takes it; valid stays high into the next call
  task automatic push_sample(input logic signed [SB-1:0] s, input logic start,
                             input logic stop);
    while (!no_gaps && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    frame_start_i <= start;
    frame_end_i <= stop;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    samples_sent++;
  endtask

  // mostly quiet material around the threshold, some extremes, some full scale
  function automatic logic signed [SB-1:0] pick_sample(input int thr);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        v = $urandom_range(thr + 1);
        if ($urandom_range(1)) v = -v;
      end
      4: begin
        // right at the knee
        v = thr - 1 + $urandom_range(2);
        if ($urandom_range(1)) v = -v;
      end
      5: begin
        case ($urandom_range(4))
          0:       v = -MAX_POS - 1;
          1:       v = MAX_POS;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      default: v = $urandom_range(2 * MAX_POS + 1) - MAX_POS - 1;
    endcase
    if (v > MAX_POS) v = MAX_POS;
    if (v < -MAX_POS - 1) v = -MAX_POS - 1;
    return SB'(v);
  endfunction

  // well-formed frames with random content, plus some stray samples with
  // random flags (start without end, end without start, both, neither)
  task automatic random_traffic(input int count);
    int sent_here;
    int len;
    sent_here = 0;
    while (sent_here < count) begin
      if ($urandom_range(9) == 0) begin
        push_sample(pick_sample(cur_thr), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent_here++;
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(200, 60) : $urandom_range(24, 1);
        for (int i = 0; i < len; i++) begin
          push_sample(pick_sample(cur_thr), i == 0, i == len - 1);
        end
        sent_here += len;
      end
    end
  endtask

  // drop valid and wait for every outstanding result plus the pipeline depth
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_count != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // one write request; valid is left high for a following write
  task automatic cfg_write(input logic [dexg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dexg_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // all four registers, junk in the bits above each width, then a write to
  // an unused index that the block must drop
  task automatic load_settings(input int thr, input logic [31:0] inv,
                               input int depth, input int coeff);
    cur_thr = thr;
    cfg_write(dexg_pkg::CFG_THRESHOLD, ($urandom & ~32'h7FFF) | 32'(thr));
    cfg_write(dexg_pkg::CFG_INV_THR, inv);
    cfg_write(dexg_pkg::CFG_DEPTH, ($urandom & ~32'hFFFF) | 32'(depth));
    cfg_write(dexg_pkg::CFG_COEFF, ($urandom & ~32'hFFFF) | 32'(coeff));
    cfg_write(IDX_W'($urandom_range((1 << IDX_W) - 1, dexg_pkg::CFG_COEFF + 1)),
              $urandom);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int thr;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings; no frame start yet, so gain and sum just run on
    push_sample(0, 1'b0, 1'b0);
    push_sample(1, 1'b0, 1'b0);
    push_sample(-1, 1'b0, 1'b0);
    // just below, at and around the knee
    push_sample(1035, 1'b0, 1'b0);
    push_sample(1036, 1'b0, 1'b0);
    push_sample(-1036, 1'b0, 1'b0);
    push_sample(-1035, 1'b0, 1'b0);
    // full scale both ways, most negative sample never below the knee
    push_sample(MAX_POS, 1'b0, 1'b0);
    push_sample(-MAX_POS - 1, 1'b0, 1'b0);
    // a short frame with alternating bit patterns
    push_sample(16'sh5555, 1'b1, 1'b0);
    push_sample(16'shAAAA, 1'b0, 1'b0);
    push_sample(300, 1'b0, 1'b0);
    push_sample(7, 1'b0, 1'b1);
    // one-sample frame: start and end together
    push_sample(100, 1'b1, 1'b1);
    push_sample(0, 1'b1, 1'b0);
    push_sample(-MAX_POS - 1, 1'b0, 1'b1);
    push_sample(12, 1'b1, 1'b1);

    // long result hold-off while samples keep coming, so the input backs up
    hold_req <= 1'b1;
    random_traffic(150);

    // deepest expansion, instant gain, widest knee; no idling on either side
    quiesce();
    load_settings(MAX_POS, 32'h8000_0000 / MAX_POS, 16'hFFFF, 0);
    no_gaps <= 1'b1;
    random_traffic(200);
    no_gaps <= 1'b0;

    // zero threshold keeps the target at unity, slowest smoothing
    quiesce();
    load_settings(0, 0, 0, 16'hFFFF);
    random_traffic(100);

    // inverse far too large: ratio clamps at one
    quiesce();
    load_settings(16384, 32'hFFFF_FFFF, 32768, 32768);
    random_traffic(100);

    // smallest nonzero knee with the largest inverse
    quiesce();
    load_settings(1, 32'h8000_0000, 16'hFFFF, 16'hFFFF);
    random_traffic(80);

    // consistent random settings
    for (int i = 0; i < 5; i++) begin
      quiesce();
      thr = $urandom_range(MAX_POS, 1);
      load_settings(thr, 32'h8000_0000 / thr, $urandom_range(16'hFFFF),
                    $urandom_range(16'hFFFF));
      random_traffic(100);
    end

    // zero inverse with maximum depth holds the gain at its floor, so one
    // long frame builds up the largest reduction per sample
    quiesce();
    load_settings(MAX_POS, 0, 16'hFFFF, 0);
    for (int i = 0; i < LONG_FRAME; i++) begin
      push_sample(SB'($urandom), i == 0, i == LONG_FRAME - 1);
    end
    // next frame start must clear the large sum
    random_traffic(50);

    quiesce();
    repeat (LATENCY) @(posedge clk_i);

    $display("run covered %0d samples (%0d results checked) over %0d register settings",
             samples_sent, checked_count, settings_used);
    $display("%0d frame ends seen, reduction sum ceiling %s", frame_end_count,
             ceiling_hit ? "reached" : "not reached");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
